### rtl/rdwr_pkg.sv
// Shared types and constants for the random draw without replacement block.
// Used by rdwr_pool and by the top level; no other dependencies.
`default_nettype none

package rdwr_pkg;

   // Default parameter values for the top level.
   localparam int POOL_DEPTH_DEFAULT  = 256;
   localparam int RANDOM_BITS_DEFAULT = 31;

   // Fixed field widths.
   localparam int VALUE_W = 8;
   localparam int CFG_W   = 9;

   // Register indexes, selected by bit 2 of the byte address.
   localparam logic REG_POOL_SIZE    = 1'b0;
   localparam logic REG_SAMPLE_COUNT = 1'b1;

   // Commands from the draw controller to the pool sequencer.
   typedef struct packed {
      logic reload;
      logic extract;
   } pool_cmd_type;

endpackage : rdwr_pkg

`default_nettype wire

### rtl/rdwr_divmod.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
// Standalone; takes no package items.
`default_nettype none

module rdwr_divmod #(
   parameter int RW = 31,   // dividend bits
   parameter int CW = 9,    // divisor bits
   parameter int IW = 8     // remainder bits (remainder is below the divisor)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [RW-1:0] dividend,
   input  wire logic [CW-1:0] divisor,
   output logic               busy,
   output logic [IW-1:0]      remainder
);

   localparam int SW = (RW > 1) ? $clog2(RW) : 1;

   logic          busy_ff;
   logic [SW-1:0] step_ff;
   logic [RW-1:0] shift_ff;
   logic [CW-1:0] part_ff;
   logic [CW-1:0] div_ff;
   logic [CW:0]   trial;
   logic [CW-1:0] part_in;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {part_ff, shift_ff[RW-1]};
      if (trial >= {1'b0, div_ff}) begin
         part_in = CW'(trial - {1'b0, div_ff});
      end else begin
         part_in = CW'(trial);
      end
   end

   // Step sequencer; the dividend is consumed MSB first.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         step_ff  <= '0;
         shift_ff <= dividend;
         part_ff  <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[RW-2:0], 1'b0};
         part_ff  <= part_in;
         step_ff  <= step_ff + SW'(1);
         if (step_ff == SW'(RW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign remainder = part_ff[IW-1:0];

endmodule : rdwr_divmod

`default_nettype wire

### rtl/rdwr_pool.sv
// Pool memory and its sequencer: identity reload, and extraction of one entry
// with the later entries moved down one place. Depends on rdwr_pkg.
`default_nettype none

module rdwr_pool #(
   parameter int LIM = 256,                // usable pool entries
   parameter int CW  = $clog2(LIM + 1),    // count bits
   parameter int IW  = $clog2(LIM)         // index bits
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rdwr_pkg::pool_cmd_type cmd,
   input  wire logic [CW-1:0]         count,    // n for reload, remaining for extract
   input  wire logic [IW-1:0]         pos,
   output logic                       busy,
   output logic [rdwr_pkg::VALUE_W-1:0] value
);

   import rdwr_pkg::*;

   typedef enum logic [1:0] {PL_IDLE, PL_FILL, PL_MOVE} pool_state_type;

   pool_state_type       state_ff;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        lim_ff;
   logic [IW-1:0]        pos_ff;
   logic                 rd_vld_ff;
   logic [IW-1:0]        rd_addr_ff;
   logic [VALUE_W-1:0]   rdata_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [VALUE_W-1:0]   mem [LIM];

   logic                 rd_en;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [VALUE_W-1:0]   wr_data;

   // Read issue while moving, and the single write port shared by fill and move.
   always_comb begin
      rd_en = (state_ff == PL_MOVE) && (cnt_ff < lim_ff);
      if (state_ff == PL_FILL) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[IW-1:0];
         wr_data = VALUE_W'(cnt_ff[IW-1:0]);
      end else begin
         wr_en   = (state_ff == PL_MOVE) && rd_vld_ff && (rd_addr_ff != pos_ff);
         wr_addr = rd_addr_ff - IW'(1);
         wr_data = rdata_ff;
      end
   end

   // Pool storage with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[cnt_ff[IW-1:0]];
      end
   end

   // Sequencer: fill writes one entry a cycle; move reads one entry a cycle and,
   // but for the drawn one, writes it back one place lower in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PL_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= 1'b0;
         unique case (state_ff)
            PL_IDLE: begin
               if (cmd.reload) begin
                  state_ff <= PL_FILL;
                  cnt_ff   <= '0;
                  lim_ff   <= count;
               end else if (cmd.extract) begin
                  state_ff <= PL_MOVE;
                  cnt_ff   <= CW'(pos);
                  pos_ff   <= pos;
                  lim_ff   <= count;
               end
            end
            PL_FILL: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff + CW'(1) >= lim_ff) begin
                  state_ff <= PL_IDLE;
               end
            end
            PL_MOVE: begin
               if (rd_en) begin
                  rd_vld_ff  <= 1'b1;
                  rd_addr_ff <= cnt_ff[IW-1:0];
                  cnt_ff     <= cnt_ff + CW'(1);
               end else if (!rd_vld_ff) begin
                  state_ff <= PL_IDLE;
               end
               // The first entry read is the one drawn.
               if (rd_vld_ff && (rd_addr_ff == pos_ff)) begin
                  value_ff <= rdata_ff;
               end
            end
            default: begin
               state_ff <= PL_IDLE;
            end
         endcase
      end
   end

   assign busy  = (state_ff != PL_IDLE);
   assign value = value_ff;

endmodule : rdwr_pool

`default_nettype wire

### rtl/random_draw_without_replacement.sv
// Top level of the random draw without replacement block: stream ports,
// register port, draw controller. Depends on rdwr_pkg, rdwr_divmod, rdwr_pool.
//
//   Channel | Ports                      | Contents
//   --------+----------------------------+----------------------------------------
//   req     | req_tvalid/tready/tdata/tuser | random_word, restart flag
//   rsp     | rsp_tvalid/tready/tdata/tlast | drawn_value, last_of_sample
//   csr     | csr_psel/penable/pwrite/...   | pool_size at 0x0, sample_count at 0x4
//
// A draw runs from the request transaction to a valid result in these steps: the
// bit-serial remainder of the used random bits, the move of the later entries one
// place down in the pool memory, and the handoff to the output register. When the
// pool reloads, the identity fill of n entries runs alongside the remainder. The next
// request can be taken in the same cycle that the result becomes valid.
// Reset is synchronous; after it the first draw reloads the pool. One draw is
// in flight at a time; a finished result waits in the output register while the
// next transaction is taken, and a stalled rsp side holds only the final step.
`default_nettype none

module random_draw_without_replacement #(
   parameter int POOL_DEPTH  = rdwr_pkg::POOL_DEPTH_DEFAULT,
   parameter int RANDOM_BITS = rdwr_pkg::RANDOM_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Draw requests.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [30:0] random_word, [31] zero
   input  wire logic        req_tuser,    // [0] restart
   // Draw results.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] drawn_value
   output logic             rsp_tlast,    // last_of_sample
   // Register port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import rdwr_pkg::*;

   localparam int LIM = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
   localparam int CW  = $clog2(LIM + 1);
   localparam int IW  = $clog2(LIM);
   localparam int RW  = (RANDOM_BITS < 31) ? RANDOM_BITS : 31;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EXTRACT, ST_DELIVER} draw_state_type;

   draw_state_type     state_ff;
   logic [CFG_W-1:0]   pool_size_ff;
   logic [CFG_W-1:0]   sample_count_ff;
   logic [CW-1:0]      remaining_ff;
   logic [CW-1:0]      drawn_ff;
   logic               needs_reload_ff;
   logic               last_ff;
   logic               rsp_tvalid_ff;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic               csr_write;
   logic               reload_now;
   logic               deliver;
   logic               needs_reload_in;
   logic               rsp_tvalid_in;
   logic [CFG_W-1:0]   n_wide;
   logic [CFG_W-1:0]   m_wide;
   logic [CW-1:0]      n_eff;
   logic [CW-1:0]      m_eff;
   logic               last_in;
   pool_cmd_type       pool_cmd;
   logic [CW-1:0]      pool_count;
   logic               pool_busy;
   logic [VALUE_W-1:0] pool_value;
   logic               div_busy;
   logic [IW-1:0]      div_rem;
   logic [CW-1:0]      div_divisor;

   // Effective pool and sample sizes, clamped to their legal ranges.
   always_comb begin
      if (pool_size_ff == '0) begin
         n_wide = CFG_W'(1);
      end else if (pool_size_ff > CFG_W'(LIM)) begin
         n_wide = CFG_W'(LIM);
      end else begin
         n_wide = pool_size_ff;
      end
      if (sample_count_ff == '0) begin
         m_wide = CFG_W'(1);
      end else if (sample_count_ff > n_wide) begin
         m_wide = n_wide;
      end else begin
         m_wide = sample_count_ff;
      end
      n_eff = CW'(n_wide);
      m_eff = CW'(m_wide);
   end

   // Handshakes and the reload decision for the incoming transaction.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reload_now = needs_reload_ff || req_tuser || (remaining_ff == '0);

   // Commands to the pool and the remainder unit.
   always_comb begin
      pool_cmd.reload  = req_accept && reload_now;
      pool_cmd.extract = (state_ff == ST_RUN) && !pool_busy && !div_busy;
      pool_count       = pool_cmd.reload ? n_eff : remaining_ff;
      div_divisor      = reload_now ? n_eff : remaining_ff;
   end

   // The sample closes when m draws are done or the pool runs empty.
   assign last_in = ({1'b0, drawn_ff} + (CW + 1)'(1) >= {1'b0, m_eff})
                    || (remaining_ff == CW'(1));

   // Reload flag: a register write or a closed sample sets it, a reload at
   // request acceptance clears it.
   always_comb begin
      if (csr_write || ((state_ff == ST_EXTRACT) && !pool_busy && last_in)) begin
         needs_reload_in = 1'b1;
      end else if (req_accept && reload_now) begin
         needs_reload_in = 1'b0;
      end else begin
         needs_reload_in = needs_reload_ff;
      end
   end

   // Output valid: set when a result is loaded, cleared when it is taken.
   assign deliver = (state_ff == ST_DELIVER) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      if (deliver) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   rdwr_divmod #(
      .RW (RW),
      .CW (CW),
      .IW (IW)
   ) u_divmod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_tdata[RW-1:0]),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   rdwr_pool #(
      .LIM (LIM),
      .CW  (CW),
      .IW  (IW)
   ) u_pool (
      .clock (clock),
      .reset (reset),
      .cmd   (pool_cmd),
      .count (pool_count),
      .pos   (div_rem),
      .busy  (pool_busy),
      .value (pool_value)
   );

   // Draw controller, register writes and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pool_size_ff    <= CFG_W'(256);
         sample_count_ff <= CFG_W'(256);
         remaining_ff    <= '0;
         drawn_ff        <= '0;
         needs_reload_ff <= 1'b1;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         rsp_tvalid_ff   <= rsp_tvalid_in;
         needs_reload_ff <= needs_reload_in;
         // Any register write starts a fresh sample at the next draw.
         if (csr_write) begin
            unique case (csr_paddr[2])
               REG_POOL_SIZE:    pool_size_ff    <= csr_pwdata[CFG_W-1:0];
               REG_SAMPLE_COUNT: sample_count_ff <= csr_pwdata[CFG_W-1:0];
               default:          pool_size_ff    <= pool_size_ff;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_RUN;
                  if (reload_now) begin
                     remaining_ff <= n_eff;
                     drawn_ff     <= '0;
                  end
               end
            end
            ST_RUN: begin
               if (pool_cmd.extract) begin
                  state_ff <= ST_EXTRACT;
               end
            end
            ST_EXTRACT: begin
               if (!pool_busy) begin
                  state_ff     <= ST_DELIVER;
                  remaining_ff <= remaining_ff - CW'(1);
                  drawn_ff     <= drawn_ff + CW'(1);
                  last_ff      <= last_in;
               end
            end
            ST_DELIVER: begin
               if (deliver) begin
                  state_ff    <= ST_IDLE;
                  rsp_data_ff <= pool_value;
                  rsp_last_ff <= last_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[2])
         REG_POOL_SIZE:    csr_prdata = 32'(pool_size_ff);
         REG_SAMPLE_COUNT: csr_prdata = 32'(sample_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : random_draw_without_replacement

`default_nettype wire
